// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the status blinker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MSB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/msb_pkg.sv =====
// ----------------------------------------------------------------------------
// msb_pkg
// Types, constants and helper functions of the Morse status blinker
// ----------------------------------------------------------------------------
package msb_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int STATUS_W   = 3;
   localparam int CODE_W     = 8;
   localparam int DOT_W      = 12;
   localparam int TIMER_W    = 16;
   localparam int NUM_CODES  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [DOT_W-1:0]   DOT_TICKS_RST = 12'd100;
   localparam logic [TIMER_W-1:0] INTERVAL_RST  = 16'd1000;
   localparam logic [CODE_W-1:0]  CODE_IDLE_RST   = 8'd32;
   localparam logic [CODE_W-1:0]  CODE_READY_RST  = 8'd33;
   localparam logic [CODE_W-1:0]  CODE_ARMING_RST = 8'd64;
   localparam logic [CODE_W-1:0]  CODE_ERROR_RST  = 8'd66;

   localparam logic [CSR_IDX_W-1:0] REG_DOT_TICKS       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_IDLE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_READY      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_ARMING     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_ERROR      = 3'd5;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_PUSH = 1'b1;

   typedef enum logic [3:0] {
      PH_WAIT = 4'b0001,
      PH_ON   = 4'b0010,
      PH_OFF  = 4'b0100,
      PH_GAP  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic                operation;
      logic [STATUS_W-1:0] status;
   } req_type;

   typedef struct packed {
      logic led_lit;
      logic push_refused;
   } rsp_type;

   typedef struct packed {
      logic [DOT_W-1:0]                  dot_ticks;
      logic [TIMER_W-1:0]                repeat_interval;
      logic [NUM_CODES-1:0][CODE_W-1:0]  codes;
   } cfg_type;

   typedef struct packed {
      logic                empty;
      logic                full;
      logic [STATUS_W-1:0] head_status;
   } queue_stat_type;

   typedef struct packed {
      phase_type          phase;
      logic [TIMER_W-1:0] timer;
      logic [2:0]         left;
      logic [4:0]         pattern;
   } element_type;

   // next element of the symbol, or the closing gap when none is left
   function automatic element_type begin_element(input logic [2:0] left,
                                                 input logic [4:0] pattern,
                                                 input logic [DOT_W-1:0] dot_len);
      element_type        e;
      logic [TIMER_W-1:0] dot_ext;
      dot_ext = TIMER_W'(dot_len);
      if (left != 3'd0) begin
         e.phase   = PH_ON;
         e.timer   = pattern[0] ? (dot_ext << 2) : dot_ext;
         e.left    = left - 3'd1;
         e.pattern = pattern >> 1;
      end else begin
         e.phase   = PH_GAP;
         e.timer   = dot_ext + (dot_ext << 1);
         e.left    = left;
         e.pattern = pattern;
      end
      return e;
   endfunction

   function automatic logic [CODE_W-1:0] code_of(
         input logic [STATUS_W-1:0] status,
         input logic [NUM_CODES-1:0][CODE_W-1:0] codes);
      logic [CODE_W-1:0] c;
      if (status < STATUS_W'(NUM_CODES)) begin
         c = codes[status[1:0]];
      end else begin
         c = '0;
      end
      return c;
   endfunction

endpackage

// ===== rtl/morse_status_blinker.sv =====
// An accepted request passes the input register, then the result register, to rsp.
// Throughput: one item per cycle while rsp_ready stays high; ticks and pushes both
// finish in one pass through the sequencer and queue logic between those registers.
// Reset (synchronous, active high) empties the queue, loads the register
// defaults, selects the idle code and arms a symbol start on the first tick.
// ----------------------------------------------------------------------------
// morse_status_blinker
// Status LED driver sending a repeating Morse symbol picked from a status queue
// ----------------------------------------------------------------------------
module morse_status_blinker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  msb_pkg::req_type                req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output msb_pkg::rsp_type                rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [msb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [msb_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic                     in_valid_ff, in_valid_in;
   msb_pkg::req_type         in_item_ff;
   logic                     out_valid_ff, out_valid_in;
   msb_pkg::rsp_type         out_item_ff;

   msb_pkg::cfg_type         cfg;
   msb_pkg::queue_stat_type  qstat;
   logic                     advance;
   logic                     is_push;
   logic                     push;
   logic                     tick_en;
   logic                     pop;
   logic                     led_lit;
   msb_pkg::rsp_type         result;

   msb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // the work stage moves when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign is_push = (in_item_ff.operation == msb_pkg::OP_PUSH);
   assign push    = advance && is_push && !qstat.full;
   assign tick_en = advance && (in_item_ff.operation == msb_pkg::OP_TICK);

   msb_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_status (in_item_ff.status),
      .pop         (pop),
      .qstat       (qstat)
   );

   msb_sequencer u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .cfg     (cfg),
      .qstat   (qstat),
      .pop     (pop),
      .led_lit (led_lit)
   );

   always_comb begin
      result.led_lit      = led_lit;
      result.push_refused = is_push && qstat.full;
      in_valid_in         = (req_valid && req_ready) || (in_valid_ff && !advance);
      out_valid_in        = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ===== rtl/msb_csr.sv =====
// ----------------------------------------------------------------------------
// msb_csr
// Configuration registers: dot length, repeat interval and four code words
// ----------------------------------------------------------------------------
module msb_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [msb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [msb_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output msb_pkg::cfg_type                   cfg
);

   msb_pkg::cfg_type cfg_ff;
   msb_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            msb_pkg::REG_DOT_TICKS: begin
               cfg_in.dot_ticks = csr_wdata[msb_pkg::DOT_W-1:0];
            end
            msb_pkg::REG_REPEAT_INTERVAL: begin
               cfg_in.repeat_interval = csr_wdata[msb_pkg::TIMER_W-1:0];
            end
            msb_pkg::REG_CODE_IDLE: begin
               cfg_in.codes[0] = csr_wdata[msb_pkg::CODE_W-1:0];
            end
            msb_pkg::REG_CODE_READY: begin
               cfg_in.codes[1] = csr_wdata[msb_pkg::CODE_W-1:0];
            end
            msb_pkg::REG_CODE_ARMING: begin
               cfg_in.codes[2] = csr_wdata[msb_pkg::CODE_W-1:0];
            end
            msb_pkg::REG_CODE_ERROR: begin
               cfg_in.codes[3] = csr_wdata[msb_pkg::CODE_W-1:0];
            end
            default: begin
               // writes past the register list are dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dot_ticks       <= msb_pkg::DOT_TICKS_RST;
         cfg_ff.repeat_interval <= msb_pkg::INTERVAL_RST;
         cfg_ff.codes[0]        <= msb_pkg::CODE_IDLE_RST;
         cfg_ff.codes[1]        <= msb_pkg::CODE_READY_RST;
         cfg_ff.codes[2]        <= msb_pkg::CODE_ARMING_RST;
         cfg_ff.codes[3]        <= msb_pkg::CODE_ERROR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/msb_queue.sv =====
// ----------------------------------------------------------------------------
// msb_queue
// Small status queue with fill count; slots hold garbage until written
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msb_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic [msb_pkg::STATUS_W-1:0]      push_status,
   input  logic                              pop,
   output msb_pkg::queue_stat_type           qstat
);

   logic [msb_pkg::STATUS_W-1:0] slot_ff [msb_pkg::QUEUE_DEPTH];
   logic [msb_pkg::QPTR_W-1:0]   head_ff, head_in;
   logic [msb_pkg::QPTR_W-1:0]   tail_ff, tail_in;
   logic [msb_pkg::QFILL_W-1:0]  fill_ff, fill_in;

   function automatic logic [msb_pkg::QPTR_W-1:0] ptr_inc(
         input logic [msb_pkg::QPTR_W-1:0] p);
      logic [msb_pkg::QPTR_W-1:0] r;
      if (p == msb_pkg::QPTR_W'(msb_pkg::QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign qstat.empty       = (fill_ff == '0);
   assign qstat.full        = (fill_ff == msb_pkg::QFILL_W'(msb_pkg::QUEUE_DEPTH));
   assign qstat.head_status = slot_ff[head_ff];

   always_comb begin
      head_in = pop  ? ptr_inc(head_ff) : head_ff;
      tail_in = push ? ptr_inc(tail_ff) : tail_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_status;
      end
   end

   `MSB_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= msb_pkg::QFILL_W'(msb_pkg::QUEUE_DEPTH), "queue fill count past depth")
   `MSB_ASSERT_IMPLY(a_no_push_full, clock, reset, qstat.full, !push, "push into a full queue")
   `MSB_ASSERT_IMPLY(a_no_pop_empty, clock, reset, qstat.empty, !pop, "pop from an empty queue")

endmodule

// ===== rtl/msb_sequencer.sv =====
// ----------------------------------------------------------------------------
// msb_sequencer
// Symbol timing: element on/off phases, closing gap and repeat interval
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msb_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tick_en,
   input  msb_pkg::cfg_type         cfg,
   input  msb_pkg::queue_stat_type  qstat,
   output logic                     pop,
   output logic                     led_lit
);

   msb_pkg::element_type             elem_ff, elem_in;
   logic [msb_pkg::TIMER_W-1:0]      period_ff, period_in;
   logic [msb_pkg::CODE_W-1:0]       code_ff, code_in;

   logic [msb_pkg::DOT_W-1:0]        dot_len;
   logic [msb_pkg::TIMER_W-1:0]      period_dec;
   logic [msb_pkg::TIMER_W-1:0]      timer_dec;
   msb_pkg::element_type             mid;
   logic                             start;
   logic [msb_pkg::CODE_W-1:0]       new_code;

   always_comb begin
      dot_len    = (cfg.dot_ticks == '0) ? msb_pkg::DOT_W'(1) : cfg.dot_ticks;
      period_dec = (period_ff != '0) ? period_ff - 1'b1 : period_ff;
      timer_dec  = (elem_ff.timer != '0) ? elem_ff.timer - 1'b1 : elem_ff.timer;

      mid = elem_ff;
      if (elem_ff.phase != msb_pkg::PH_WAIT) begin
         mid.timer = timer_dec;
         if (timer_dec == '0) begin
            unique case (elem_ff.phase)
               msb_pkg::PH_ON: begin
                  mid.phase = msb_pkg::PH_OFF;
                  mid.timer = msb_pkg::TIMER_W'(dot_len);
               end
               msb_pkg::PH_OFF: begin
                  mid = msb_pkg::begin_element(elem_ff.left, elem_ff.pattern, dot_len);
               end
               msb_pkg::PH_GAP: begin
                  mid.phase = msb_pkg::PH_WAIT;
                  mid.timer = '0;
               end
               default: begin
                  mid = elem_ff;
               end
            endcase
         end
      end

      // a queued status, if any, replaces the active code at symbol start
      start    = (mid.phase == msb_pkg::PH_WAIT) && (period_dec == '0);
      new_code = qstat.empty ? code_ff : msb_pkg::code_of(qstat.head_status, cfg.codes);

      if (start) begin
         elem_in   = msb_pkg::begin_element(new_code[7:5], new_code[4:0], dot_len);
         period_in = cfg.repeat_interval;
         code_in   = new_code;
      end else begin
         elem_in   = mid;
         period_in = period_dec;
         code_in   = code_ff;
      end

      pop     = tick_en && start && !qstat.empty;
      led_lit = tick_en ? (elem_in.phase == msb_pkg::PH_ON)
                        : (elem_ff.phase == msb_pkg::PH_ON);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elem_ff.phase   <= msb_pkg::PH_WAIT;
         elem_ff.timer   <= '0;
         elem_ff.left    <= '0;
         elem_ff.pattern <= '0;
         period_ff       <= '0;
         code_ff         <= msb_pkg::CODE_IDLE_RST;
      end else if (tick_en) begin
         elem_ff   <= elem_in;
         period_ff <= period_in;
         code_ff   <= code_in;
      end
   end

   `MSB_ASSERT_IMPLY(a_timer_live, clock, reset, elem_ff.phase != msb_pkg::PH_WAIT, elem_ff.timer != '0, "running phase with expired timer")
   `MSB_ASSERT_IMPLY(a_timer_idle, clock, reset, elem_ff.phase == msb_pkg::PH_WAIT, elem_ff.timer == '0, "waiting phase with running timer")

endmodule

// ===== dv/msb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_checker
// Watches the request, result and register channels of the Morse status
// blinker, keeps its own copy of the blink sequencer and status queue, and
// compares every result beat against the LED state and refusal it forecasts.
// ----------------------------------------------------------------------------
module msb_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  msb_pkg::req_type                req_item,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  msb_pkg::rsp_type                rsp_item,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [msb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [msb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              outstanding
);

   // register copies
   logic [msb_pkg::DOT_W-1:0]    dot_setting;
   logic [msb_pkg::TIMER_W-1:0]  interval_setting;
   logic [msb_pkg::CODE_W-1:0]   code_table [msb_pkg::NUM_CODES];

   // sequencer copy
   logic [msb_pkg::STATUS_W-1:0] status_fifo [msb_pkg::QUEUE_DEPTH];
   int unsigned                  fifo_count;
   int unsigned                  fifo_rd;
   int unsigned                  fifo_wr;
   logic [msb_pkg::CODE_W-1:0]   shown_code;
   logic [4:0]                   pattern_left;
   logic [2:0]                   marks_left;
   msb_pkg::phase_type           phase;
   logic [msb_pkg::TIMER_W-1:0]  phase_ticks;
   logic [msb_pkg::TIMER_W-1:0]  period_ticks;

   msb_pkg::rsp_type             led_forecast [$];
   int                           result_beats;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      result_beats   = 0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch on result beat %0d: %s", $time, result_beats, what);
   endtask

   function automatic void clear_model();
      dot_setting      = msb_pkg::DOT_TICKS_RST;
      interval_setting = msb_pkg::INTERVAL_RST;
      code_table[0]    = msb_pkg::CODE_IDLE_RST;
      code_table[1]    = msb_pkg::CODE_READY_RST;
      code_table[2]    = msb_pkg::CODE_ARMING_RST;
      code_table[3]    = msb_pkg::CODE_ERROR_RST;
      foreach (status_fifo[i]) status_fifo[i] = '0;
      fifo_count   = 0;
      fifo_rd      = 0;
      fifo_wr      = 0;
      shown_code   = msb_pkg::CODE_IDLE_RST;
      pattern_left = '0;
      marks_left   = '0;
      phase        = msb_pkg::PH_WAIT;
      phase_ticks  = '0;
      period_ticks = '0;
   endfunction

   function automatic void load_register(input logic [msb_pkg::CSR_IDX_W-1:0]  idx,
                                         input logic [msb_pkg::CSR_DATA_W-1:0] data);
      case (idx)
         msb_pkg::REG_DOT_TICKS:       dot_setting      = data[msb_pkg::DOT_W-1:0];
         msb_pkg::REG_REPEAT_INTERVAL: interval_setting = data[msb_pkg::TIMER_W-1:0];
         msb_pkg::REG_CODE_IDLE:       code_table[0]    = data[msb_pkg::CODE_W-1:0];
         msb_pkg::REG_CODE_READY:      code_table[1]    = data[msb_pkg::CODE_W-1:0];
         msb_pkg::REG_CODE_ARMING:     code_table[2]    = data[msb_pkg::CODE_W-1:0];
         msb_pkg::REG_CODE_ERROR:      code_table[3]    = data[msb_pkg::CODE_W-1:0];
         default: ;
      endcase
   endfunction

   // a zero dot length behaves as one tick
   function automatic logic [msb_pkg::TIMER_W-1:0] dot_span();
      return (dot_setting == '0) ? msb_pkg::TIMER_W'(1) : msb_pkg::TIMER_W'(dot_setting);
   endfunction

   function automatic void open_element();
      if (marks_left != 3'd0) begin
         marks_left   = marks_left - 3'd1;
         phase        = msb_pkg::PH_ON;
         phase_ticks  = pattern_left[0] ? msb_pkg::TIMER_W'(dot_span() * 4) : dot_span();
         pattern_left = pattern_left >> 1;
      end else begin
         phase       = msb_pkg::PH_GAP;
         phase_ticks = msb_pkg::TIMER_W'(dot_span() * 3);
      end
   endfunction

   function automatic void launch_symbol();
      logic [msb_pkg::STATUS_W-1:0] st;
      if (fifo_count != 0) begin
         st         = status_fifo[fifo_rd];
         shown_code = (st < msb_pkg::NUM_CODES) ? code_table[st[1:0]] : '0;
         fifo_rd    = (fifo_rd + 1) % msb_pkg::QUEUE_DEPTH;
         fifo_count--;
      end
      period_ticks = interval_setting;
      marks_left   = shown_code[7:5];
      pattern_left = shown_code[4:0];
      open_element();
   endfunction

   function automatic void end_phase();
      case (phase)
         msb_pkg::PH_ON: begin
            phase       = msb_pkg::PH_OFF;
            phase_ticks = dot_span();
         end
         msb_pkg::PH_OFF: open_element();
         default: begin
            phase       = msb_pkg::PH_WAIT;
            phase_ticks = '0;
         end
      endcase
   endfunction

   function automatic msb_pkg::rsp_type advance_blinker(input msb_pkg::req_type it);
      msb_pkg::rsp_type r;
      r = '0;
      if (it.operation == msb_pkg::OP_PUSH) begin
         if (fifo_count >= msb_pkg::QUEUE_DEPTH) begin
            r.push_refused = 1'b1;
         end else begin
            status_fifo[fifo_wr] = it.status;
            fifo_wr = (fifo_wr + 1) % msb_pkg::QUEUE_DEPTH;
            fifo_count++;
         end
      end else begin
         if (period_ticks != '0) period_ticks = period_ticks - 1'b1;
         if (phase != msb_pkg::PH_WAIT) begin
            if (phase_ticks != '0) phase_ticks = phase_ticks - 1'b1;
            if (phase_ticks == '0) end_phase();
         end
         if (phase == msb_pkg::PH_WAIT && period_ticks == '0) launch_symbol();
      end
      r.led_lit = (phase == msb_pkg::PH_ON);
      return r;
   endfunction

   always @(posedge clock) begin
      msb_pkg::rsp_type want;
      if (reset) begin
         clear_model();
         led_forecast.delete();
      end else begin
         if (csr_valid && csr_ready) load_register(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready) begin
            if (led_forecast.size() == 0) begin
               report_mismatch("result beat with nothing outstanding");
            end else begin
               want = led_forecast.pop_front();
               if (rsp_item.led_lit !== want.led_lit)
                  report_mismatch($sformatf("led_lit %b, expected %b",
                                            rsp_item.led_lit, want.led_lit));
               if (rsp_item.push_refused !== want.push_refused)
                  report_mismatch($sformatf("push_refused %b, expected %b",
                                            rsp_item.push_refused, want.push_refused));
            end
            result_beats++;
         end
         if (req_valid && req_ready) led_forecast.push_back(advance_blinker(req_item));
      end
      outstanding <= led_forecast.size();
   end

endmodule

// ===== dv/tb_morse_status_blinker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_status_blinker
// Drives ticks and status pushes into the blinker under a series of timing
// and code settings, with random idling on both channels; the checker beside
// the block forecasts every LED state and refusal and counts mismatches.
// ----------------------------------------------------------------------------
module tb_morse_status_blinker;

   localparam int STALL_LIMIT = 2000;
   // index with no register behind it, writes must be dropped
   localparam logic [msb_pkg::CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   msb_pkg::req_type               req_item  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   msb_pkg::rsp_type               rsp_item;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [msb_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [msb_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches;
   int outstanding;
   bit steady          = 1'b0;
   int stall_cycles    = 0;
   int sent_items      = 0;
   int sent_pushes     = 0;
   int refusals_seen   = 0;
   int lit_beats       = 0;
   int settings_loaded = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   morse_status_blinker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   msb_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .outstanding    (outstanding)
   );

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 37);
   end

   // watchdog: cycles without any beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (rsp_valid && rsp_ready) begin
         refusals_seen += rsp_item.push_refused;
         lit_beats     += rsp_item.led_lit;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic msb_pkg::req_type make_item(input logic op,
                                                  input logic [msb_pkg::STATUS_W-1:0] s);
      msb_pkg::req_type it;
      it.operation = op;
      it.status    = s;
      return it;
   endfunction

   // mostly mapped statuses, the rest unmapped
   function automatic logic [msb_pkg::STATUS_W-1:0] pick_status();
      return ($urandom_range(99) < 80) ? msb_pkg::STATUS_W'($urandom_range(3))
                                       : msb_pkg::STATUS_W'($urandom_range(7, 4));
   endfunction

   task automatic send_item(input msb_pkg::req_type it);
      while (!steady && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_items++;
      if (it.operation == msb_pkg::OP_PUSH) sent_pushes++;
   endtask

   // hold the sender off until every result beat is back
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // csr_valid stays high across back-to-back writes, caller lowers it
   task automatic write_reg(input logic [msb_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [msb_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // upper data bits carry junk that the block must drop
   task automatic set_timing(input logic [msb_pkg::DOT_W-1:0] dot,
                             input logic [msb_pkg::TIMER_W-1:0] span);
      drain();
      write_reg(msb_pkg::REG_DOT_TICKS, {4'($urandom), dot});
      write_reg(msb_pkg::REG_REPEAT_INTERVAL, span);
      write_reg(REG_SPARE, 16'($urandom));
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic set_codes(input logic [msb_pkg::CODE_W-1:0] c_idle,
                            input logic [msb_pkg::CODE_W-1:0] c_ready,
                            input logic [msb_pkg::CODE_W-1:0] c_arming,
                            input logic [msb_pkg::CODE_W-1:0] c_error);
      drain();
      write_reg(msb_pkg::REG_CODE_IDLE,   {8'($urandom), c_idle});
      write_reg(msb_pkg::REG_CODE_READY,  {8'($urandom), c_ready});
      write_reg(msb_pkg::REG_CODE_ARMING, {8'($urandom), c_arming});
      write_reg(msb_pkg::REG_CODE_ERROR,  {8'($urandom), c_error});
      csr_valid <= 1'b0;
   endtask

   task automatic set_random_codes();
      set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic run_phase(input int n);
      int k;
      int burst;
      bit paused;
      k      = 0;
      paused = 1'b0;
      while (k < n) begin
         if (!paused && k >= n / 2) begin
            drain();
            paused = 1'b1;
         end
         if ($urandom_range(24) == 0) begin
            // push burst, overruns the queue now and then
            burst = $urandom_range(6, 4);
            repeat (burst) send_item(make_item(msb_pkg::OP_PUSH, pick_status()));
            k += burst;
         end else begin
            send_item(make_item(($urandom_range(99) < 20) ? msb_pkg::OP_PUSH
                                                          : msb_pkg::OP_TICK,
                                msb_pkg::STATUS_W'($urandom)));
            k++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the queue under reset codes, then overflow it with unmapped statuses
      for (int s = 0; s < msb_pkg::NUM_CODES; s++) begin
         send_item(make_item(msb_pkg::OP_PUSH, msb_pkg::STATUS_W'(s)));
      end
      send_item(make_item(msb_pkg::OP_PUSH, 3'd7));
      send_item(make_item(msb_pkg::OP_PUSH, 3'd4));
      set_timing(12'd1, 16'd0);
      repeat (20) send_item(make_item(msb_pkg::OP_TICK, msb_pkg::STATUS_W'($urandom)));

      // zero dot and interval, long codes, empty code, length-zero code with pattern
      set_timing(12'd0, 16'd0);
      set_codes(8'hFF, 8'hE0, 8'h00, 8'h1F);
      run_phase(250);

      // interval shorter than most symbols
      set_timing(12'd2, 16'd6);
      set_random_codes();
      run_phase(250);

      // no idling on either side here
      steady = 1'b1;
      set_timing(12'd1, 16'd60);
      set_random_codes();
      run_phase(250);
      steady = 1'b0;

      set_timing(12'($urandom_range(3, 1)), 16'($urandom_range(30)));
      set_random_codes();
      run_phase(300);

      set_timing(12'd3, 16'd1);
      set_codes(8'h00, 8'hFF, 8'hA5, 8'($urandom));
      run_phase(250);

      // longest dot and interval last, they freeze the symbol for a long time
      set_timing(12'hFFF, 16'hFFFF);
      set_codes(8'hFF, 8'h00, 8'($urandom), 8'($urandom));
      run_phase(100);

      drain();
      repeat (4) @(posedge clock);
      $display("ran %0d items (%0d status pushes) across %0d timing settings",
               sent_items, sent_pushes, settings_loaded);
      $display("saw %0d refused pushes and %0d results with the LED lit",
               refusals_seen, lit_beats);
      if (mismatches == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== morse_status_blinker.f =====
+incdir+rtl
rtl/msb_pkg.sv
rtl/msb_csr.sv
rtl/msb_queue.sv
rtl/msb_sequencer.sv
rtl/morse_status_blinker.sv
dv/msb_checker.sv
dv/tb_morse_status_blinker.sv
